FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by sorted_pair_table_by_lag.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define AST_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Overlapping implication outside reset
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication outside reset
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: sv/spt_pkg.sv
// ---------------------------------------------------------------------------
// spt_pkg
// Types, request and status codes and default sizes of the sorted pair table.
// ---------------------------------------------------------------------------
package spt_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int LAG_SPAN_DEF    = 10000;

  // Request codes
  localparam logic [2:0] REQ_ADD   = 3'd0;
  localparam logic [2:0] REQ_FIN   = 3'd1;
  localparam logic [2:0] REQ_BOUND = 3'd2;
  localparam logic [2:0] REQ_PAIR  = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_UNSORTED = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [15:0]        first_sample;
    logic [15:0]        second_sample;
    logic [13:0]        lag_index;
    logic [3:0]         direction_index;
    logic signed [31:0] pair_distance;
    logic [9:0]         sorted_rank;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [10:0]        range_first;
    logic signed [11:0] range_end;
    logic [15:0]        out_first_sample;
    logic [15:0]        out_second_sample;
    logic signed [31:0] out_distance;
    logic               distance_valid;
    logic [10:0]        pair_count;
  } out_t;

endpackage

FILE: sv/spt_ram.sv
// ---------------------------------------------------------------------------
// spt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module spt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/sorted_pair_table_by_lag.sv
// Add, clear and unknown requests pass from S_EXEC to S_DONE, which hands the result
// over once the output register is free. Pair query: order RAM read, then entry RAM
// read. Bounds query: per sorted entry scanned, an order RAM read, an entry RAM read
// and a compare. Finalize: a rank count that compares every key pair through the
// single entry RAM read port. One item at a time; the next is taken while a result waits.
// Reset (synchronous, rst_n low) empties the table, clears the sorted flag and the option.
// ---------------------------------------------------------------------------
// sorted_pair_table_by_lag
// Pair table with a stable rank order by key, bounds lookup and pair lookup.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_pair_table_by_lag #(
  parameter int TABLE_DEPTH = spt_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = spt_pkg::SAMPLE_BITS_DEF,
  parameter int LAG_SPAN    = spt_pkg::LAG_SPAN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  spt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output spt_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W = $clog2(15 * LAG_SPAN + 16384);
  localparam int SB    = SAMPLE_BITS;
  localparam int EW    = KEY_W + 32 + 2 * SB;
  localparam int F_LO  = 0;
  localparam int S_LO  = SB;
  localparam int D_LO  = 2 * SB;
  localparam int K_LO  = 2 * SB + 32;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SORT_KI, S_SORT_KW, S_SORT_RD, S_SORT_CMP, S_SORT_WR,
    S_BND_ORD, S_BND_ENT, S_BND_CMP, S_QRY_ORD, S_QRY_ENT, S_QRY_OUT, S_DONE
  } state_t;

  state_t          state_r;
  spt_pkg::in_t    in_r;
  spt_pkg::out_t   res_r;
  spt_pkg::out_t   out_r;
  logic            out_valid_r;
  logic            store_dist_r;
  logic [CNT_W-1:0] count_r;
  logic            sorted_r;
  logic [CNT_W-1:0] i_r;
  logic [CNT_W-1:0] j_r;
  logic [CNT_W-1:0] rank_r;
  logic [CNT_W-1:0] first_r;
  logic            found_r;
  logic [KEY_W-1:0] keyi_r;

  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr;
  logic [EW-1:0]    ent_wdata;
  logic [IDX_W-1:0] ent_raddr;
  logic [EW-1:0]    ent_rdata;
  logic             ord_we;
  logic [IDX_W-1:0] ord_waddr;
  logic [IDX_W-1:0] ord_wdata;
  logic [IDX_W-1:0] ord_raddr;
  logic [IDX_W-1:0] ord_rdata;

  logic [KEY_W-1:0] req_key;
  logic [KEY_W-1:0] rd_key;
  logic             positive;
  logic [SB-1:0]    samp_a;
  logic [SB-1:0]    samp_b;
  logic             b_hit;
  logic [CNT_W-1:0] b_first;
  logic             b_found;
  logic             key_less;
  logic             last_i;
  logic             last_j;
  logic             room;

  spt_pkg::out_t    exec_res_nxt;
  state_t           exec_state_nxt;
  spt_pkg::out_t    out_nxt;
  logic             out_full;

  // Key, sample order and scan helpers
  always_comb begin
    req_key  = KEY_W'(in_r.lag_index) + KEY_W'(in_r.direction_index) * KEY_W'(LAG_SPAN);
    rd_key   = ent_rdata[K_LO +: KEY_W];
    positive = (in_r.pair_distance != 32'sd0) && !in_r.pair_distance[31];
    samp_a   = SB'(in_r.first_sample);
    samp_b   = SB'(in_r.second_sample);
    b_hit    = (rd_key == req_key);
    b_found  = found_r || b_hit;
    b_first  = (b_hit && !found_r) ? i_r : first_r;
    key_less = (rd_key < keyi_r) || ((rd_key == keyi_r) && (j_r < i_r));
    last_i   = (i_r + CNT_W'(1)) == count_r;
    last_j   = (j_r + CNT_W'(1)) == count_r;
    room     = count_r < CNT_W'(TABLE_DEPTH);
  end

  // Immediate result and follow-on state of a request, and the item to hand over
  always_comb begin
    exec_res_nxt   = '0;
    exec_state_nxt = S_DONE;
    case (in_r.req_type)
      spt_pkg::REQ_ADD: begin
        if (!room) begin
          exec_res_nxt.status = spt_pkg::ST_FULL;
        end
      end
      spt_pkg::REQ_FIN: begin
        if (count_r != '0) begin
          exec_state_nxt = S_SORT_KI;
        end
      end
      spt_pkg::REQ_BOUND: begin
        if (!sorted_r) begin
          exec_res_nxt.status = spt_pkg::ST_UNSORTED;
        end else if (count_r == '0) begin
          exec_res_nxt.range_end = -12'sd1;
        end else begin
          exec_state_nxt = S_BND_ORD;
        end
      end
      spt_pkg::REQ_PAIR: begin
        if (!sorted_r) begin
          exec_res_nxt.status = spt_pkg::ST_UNSORTED;
        end else if (32'(in_r.sorted_rank) < 32'(count_r)) begin
          exec_state_nxt = S_QRY_ORD;
        end
      end
      default: ;
    endcase
    out_nxt            = res_r;
    out_nxt.pair_count = 11'(count_r);
  end

  // Memory port control
  always_comb begin
    ent_we    = (state_r == S_EXEC) && (in_r.req_type == spt_pkg::REQ_ADD) && room;
    ent_waddr = count_r[IDX_W-1:0];
    ent_wdata = {req_key, (store_dist_r ? in_r.pair_distance : 32'sd0),
                 (positive ? samp_b : samp_a), (positive ? samp_a : samp_b)};
    ord_we    = (state_r == S_SORT_WR);
    ord_waddr = rank_r[IDX_W-1:0];
    ord_wdata = i_r[IDX_W-1:0];
    ent_raddr = '0;
    ord_raddr = '0;
    case (state_r)
      S_SORT_KI: ent_raddr = i_r[IDX_W-1:0];
      S_SORT_RD: ent_raddr = j_r[IDX_W-1:0];
      S_BND_ENT: ent_raddr = ord_rdata;
      S_QRY_ENT: ent_raddr = ord_rdata;
      S_BND_ORD: ord_raddr = i_r[IDX_W-1:0];
      S_QRY_ORD: ord_raddr = IDX_W'(in_r.sorted_rank);
      default: ;
    endcase
  end

  spt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  spt_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_DEPTH)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  // Sequencer, table state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      store_dist_r <= 1'b0;
      count_r      <= '0;
      sorted_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        store_dist_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_r   <= exec_res_nxt;
          i_r     <= '0;
          first_r <= count_r;
          found_r <= 1'b0;
          state_r <= exec_state_nxt;
          case (in_r.req_type)
            spt_pkg::REQ_ADD: begin
              if (room) begin
                count_r  <= count_r + CNT_W'(1);
                sorted_r <= 1'b0;
              end
            end
            spt_pkg::REQ_FIN: begin
              if (count_r == '0) begin
                sorted_r <= 1'b1;
              end
            end
            spt_pkg::REQ_CLEAR: begin
              count_r  <= '0;
              sorted_r <= 1'b0;
            end
            default: ;
          endcase
        end
        // Count the keys ranked ahead of entry i, then place i
        S_SORT_KI: state_r <= S_SORT_KW;
        S_SORT_KW: begin
          keyi_r  <= rd_key;
          j_r     <= '0;
          rank_r  <= '0;
          state_r <= S_SORT_RD;
        end
        S_SORT_RD: state_r <= S_SORT_CMP;
        S_SORT_CMP: begin
          if (key_less) begin
            rank_r <= rank_r + CNT_W'(1);
          end
          j_r     <= j_r + CNT_W'(1);
          state_r <= last_j ? S_SORT_WR : S_SORT_RD;
        end
        S_SORT_WR: begin
          i_r <= i_r + CNT_W'(1);
          if (last_i) begin
            sorted_r <= 1'b1;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_SORT_KI;
          end
        end
        // Walk sorted ranks until the key run ends
        S_BND_ORD: state_r <= S_BND_ENT;
        S_BND_ENT: state_r <= S_BND_CMP;
        S_BND_CMP: begin
          first_r <= b_first;
          found_r <= b_found;
          i_r     <= i_r + CNT_W'(1);
          if (!b_hit && found_r) begin
            res_r.range_first <= 11'(first_r);
            res_r.range_end   <= 12'(i_r);
            state_r           <= S_DONE;
          end else if (last_i) begin
            res_r.range_first <= 11'(b_first);
            res_r.range_end   <= b_found ? 12'(count_r) : -12'sd1;
            state_r           <= S_DONE;
          end else begin
            state_r <= S_BND_ORD;
          end
        end
        S_QRY_ORD: state_r <= S_QRY_ENT;
        S_QRY_ENT: state_r <= S_QRY_OUT;
        S_QRY_OUT: begin
          res_r.out_first_sample  <= 16'(ent_rdata[F_LO +: SB]);
          res_r.out_second_sample <= 16'(ent_rdata[S_LO +: SB]);
          res_r.distance_valid    <= store_dist_r;
          res_r.out_distance      <= store_dist_r ? ent_rdata[D_LO +: 32] : 32'sd0;
          state_r                 <= S_DONE;
        end
        // Hand the result over once the output register is free
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= out_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_full  = out_valid_r && (out_r.status == spt_pkg::ST_FULL);

  `AST_PROP(a_count_bound, clk, rst_n, count_r <= CNT_W'(TABLE_DEPTH))
  `AST_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_r == S_EXEC)
  `AST_IMPL(a_full_status, clk, rst_n, out_full, out_r.pair_count == 11'(TABLE_DEPTH))
  `AST_NEXT(a_fin_sorted, clk, rst_n, (state_r == S_SORT_WR) && last_i, sorted_r)

endmodule
